// ===== sv/cfb_pkg.sv =====
// Shared types, constants and the word-wide CRC32 update for the command frame builder.
// Depends on nothing; every other file of the block imports it.
package cfb_pkg;

   localparam logic [15:0] SIGN_WORD = 16'h484C;
   localparam logic [31:0] CRC_POLY  = 32'h04C11DB7;
   localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DROPPED = 2'd1;
   localparam logic [1:0] STATUS_ABORTED = 2'd2;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      OP_START,
      OP_DATA,
      OP_DROP
   } op_kind_type;

   // One classified transaction, handed from the front to the back.
   typedef struct packed {
      op_kind_type kind;
      logic [31:0] word0;   // first header word, or the masked payload word
      logic [31:0] word1;   // second header word
      logic        close;   // the CRC word follows and ends the frame
      logic [1:0]  status;
   } op_type;

   // CRC32, MSB first, one whole 32-bit word per call.
   function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] data);
      logic [31:0] c;
      c = crc;
      for (int k = 31; k >= 0; k--) begin
         if (c[31] ^ data[k]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/cfb_front.sv =====
// Front end of the command frame builder: classifies each input transaction and tracks
// the open frame and the payload bytes still expected. Depends on cfb_pkg.
module cfb_front #(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            command,
   input  logic [15:0]     request_code,
   input  logic [15:0]     sequence_number,
   input  logic [10:0]     payload_bytes,
   input  logic [31:0]     payload_word,
   output cfb_pkg::op_type op
);
   import cfb_pkg::*;

   localparam int LIMIT = MAX_FRAME_BYTES - 12;

   logic [10:0] bytes_left_ff, bytes_left_in;
   logic        frame_open_ff, frame_open_in;
   logic [10:0] len_sat;
   logic [11:0] rounded;
   logic [31:0] mask;

   always_comb begin
      if ({6'd0, payload_bytes} > 17'(LIMIT)) begin
         len_sat = 11'(LIMIT);
      end else begin
         len_sat = payload_bytes;
      end
      rounded = ({1'b0, len_sat} + 12'd3) & ~12'd3;
      case (bytes_left_ff[1:0])
         2'd1:    mask = 32'h000000FF;
         2'd2:    mask = 32'h0000FFFF;
         2'd3:    mask = 32'h00FFFFFF;
         default: mask = 32'hFFFFFFFF;
      endcase
   end

   always_comb begin
      op            = '0;
      bytes_left_in = bytes_left_ff;
      frame_open_in = frame_open_ff;
      if (command == CMD_START) begin
         op.kind       = OP_START;
         op.word0      = {request_code, SIGN_WORD};
         op.word1      = {4'd0, rounded, sequence_number};
         op.close      = (len_sat == 11'd0);
         op.status     = frame_open_ff ? STATUS_ABORTED : STATUS_OK;
         bytes_left_in = len_sat;
         frame_open_in = (len_sat != 11'd0);
      end else if (!frame_open_ff) begin
         op.kind   = OP_DROP;
         op.status = STATUS_DROPPED;
      end else begin
         op.kind   = OP_DATA;
         op.status = STATUS_OK;
         if (bytes_left_ff < 11'd4) begin
            op.word0      = payload_word & mask;
            bytes_left_in = 11'd0;
         end else begin
            op.word0      = payload_word;
            bytes_left_in = bytes_left_ff - 11'd4;
         end
         op.close      = (bytes_left_in == 11'd0);
         frame_open_in = (bytes_left_in != 11'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         frame_open_ff <= 1'b0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

// ===== sv/cfb_op_fifo.sv =====
// Short register queue of classified transactions between front and back.
// Depends on cfb_pkg for the entry type.
module cfb_op_fifo #(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            write,
   input  cfb_pkg::op_type write_data,
   input  logic            read,
   output cfb_pkg::op_type read_data,
   output logic            full,
   output logic            empty
);
   import cfb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_write, do_read;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_write  = write && !full;
   assign do_read   = read && !empty;
   assign read_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_write) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_read) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_write && !do_read) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_read && !do_write) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/cfb_back.sv =====
// Back end of the command frame builder: expands each queued transaction into frame words,
// runs the CRC32 and holds the result register. Depends on cfb_pkg.
module cfb_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  cfb_pkg::op_type op,
   output logic            op_done,
   output logic            rsp_valid,
   input  logic            rsp_take,
   output logic [31:0]     frame_word,
   output logic            last,
   output logic [1:0]      status
);
   import cfb_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [31:0] crc_ff, crc_in;
   logic        valid_ff;
   logic [31:0] word_ff, word_in;
   logic        last_ff, last_in;
   logic [1:0]  status_ff;
   logic        step, emit_crc, use_crc, finish;
   logic [31:0] data_word, crc_base, crc_next;

   assign step = op_valid && (!valid_ff || rsp_take);

   always_comb begin
      emit_crc  = 1'b0;
      use_crc   = 1'b0;
      finish    = 1'b0;
      data_word = op.word0;
      crc_base  = crc_ff;
      unique case (op.kind)
         OP_START: begin
            use_crc = 1'b1;
            if (phase_ff == 2'd0) begin
               crc_base = CRC_INIT;
            end else if (phase_ff == 2'd1) begin
               data_word = op.word1;
               finish    = !op.close;
            end else begin
               emit_crc = 1'b1;
               finish   = 1'b1;
            end
         end
         OP_DATA: begin
            use_crc = 1'b1;
            if (phase_ff == 2'd0) begin
               finish = !op.close;
            end else begin
               emit_crc = 1'b1;
               finish   = 1'b1;
            end
         end
         default: begin
            data_word = '0;
            finish    = 1'b1;
         end
      endcase
      crc_next = crc_word(crc_base, data_word);
   end

   always_comb begin
      crc_in   = crc_ff;
      phase_in = phase_ff;
      word_in  = data_word;
      last_in  = 1'b0;
      if (emit_crc) begin
         word_in = crc_ff;
         last_in = 1'b1;
         crc_in  = CRC_INIT;
      end else if (use_crc) begin
         crc_in = crc_next;
      end
      phase_in = finish ? 2'd0 : phase_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            crc_ff   <= crc_in;
            valid_ff <= 1'b1;
         end else if (rsp_take) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         word_ff   <= word_in;
         last_ff   <= last_in;
         status_ff <= op.status;
      end
   end

   assign op_done    = step && finish;
   assign rsp_valid  = valid_ff;
   assign frame_word = word_ff;
   assign last       = last_ff;
   assign status     = status_ff;

endmodule

// ===== sv/command_frame_builder_crc32_unit.sv =====
// Top level of the command frame builder with word-wide CRC32.
// Instantiates cfb_front, cfb_op_fifo and cfb_back; depends on cfb_pkg.
//
// Usage. The input side looks like a queue: a transaction is taken at a rising edge
// with push high and full low. A start transaction (req_command = 0) opens a frame and
// yields two header words, plus the CRC word at once when the payload length is zero.
// A payload transaction (req_command = 1) yields one payload word, plus the closing CRC
// word when the announced bytes are used up. The result side also looks like a queue:
// while empty is low the oldest frame word is on rsp_frame_word, rsp_last and
// rsp_status, and it is taken at a rising edge with pop high.
// With the queue and the result register idle, a taken transaction is written into the
// queue, and the back end then loads its first frame word into the result register.
// The back end emits one frame word per cycle while the receiver takes each word, so a
// payload transaction yields one word (two when it closes the frame) and a start
// transaction two or three. The word-wide CRC update in the back end sets that rate.
// A four-entry transaction queue separates the front from the back, so input keeps
// flowing while a result waits; when the receiver stalls the queue fills and full rises.
// Reset clears the frame state, empties the queue and the result register, and sets the
// running CRC to all ones; no frame is open after reset.
module command_frame_builder_crc32_unit #(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_command,
   input  logic [15:0] req_request_code,
   input  logic [15:0] req_sequence_number,
   input  logic [10:0] req_payload_bytes,
   input  logic [31:0] req_payload_word,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_frame_word,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);
   import cfb_pkg::*;

   localparam int QUEUE_DEPTH = 4;

   op_type front_op;
   op_type head_op;
   logic   accept;
   logic   queue_empty;
   logic   head_done;
   logic   rsp_valid;

   // A transaction enters the queue whenever the queue has room.
   assign accept = push && !full;

   cfb_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .command        (req_command),
      .request_code   (req_request_code),
      .sequence_number(req_sequence_number),
      .payload_bytes  (req_payload_bytes),
      .payload_word   (req_payload_word),
      .op             (front_op)
   );

   cfb_op_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .write     (accept),
      .write_data(front_op),
      .read      (head_done),
      .read_data (head_op),
      .full      (full),
      .empty     (queue_empty)
   );

   // The back end retires the head entry once its last frame word is loaded.
   cfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (!queue_empty),
      .op        (head_op),
      .op_done   (head_done),
      .rsp_valid (rsp_valid),
      .rsp_take  (pop),
      .frame_word(rsp_frame_word),
      .last      (rsp_last),
      .status    (rsp_status)
   );

   assign empty = !rsp_valid;

endmodule
